/* src/whid_pkg.sv */
`timescale 1ns / 1ps

package whid_pkg;

  localparam int BLOCK_COUNT_DEF = 40;
  localparam int WEIGHT_DEPTH    = 40;

  localparam int BIN_W   = 16;
  localparam int PROD_W  = 32;
  localparam int MIN_W   = 44;
  localparam int TGT_W   = 28;
  localparam int NUM_W   = MIN_W + 2;
  localparam int DSH_W   = TGT_W + 17;
  localparam int QUOT_W  = 17;
  localparam int DIST_W  = 17;
  localparam int LEN_W   = 11;
  localparam int BIB_W   = 10;

  localparam logic [LEN_W-1:0]  LEN_MAX   = 11'd1024;
  localparam logic [LEN_W-1:0]  LEN_RESET = 11'd64;
  localparam logic [DIST_W-1:0] ONE_Q16   = 17'h10000;

  localparam logic CFG_USE_WEIGHTS = 1'b0;
  localparam logic CFG_BLOCK_LEN   = 1'b1;

  localparam logic [15:0] WEIGHTS [WEIGHT_DEPTH] = '{
    16'd36386, 16'd29570, 16'd31746, 16'd25684,
    16'd35468, 16'd40272, 16'd42841, 16'd34288,
    16'd31077, 16'd40718, 16'd40691, 16'd31385,
    16'd25068, 16'd35494, 16'd38542, 16'd27610,
    16'd18081, 16'd28561, 16'd30769, 16'd20487,
    16'd14503, 16'd25710, 16'd26857, 16'd16882,
    16'd15067, 16'd22833, 16'd24314, 16'd15624,
    16'd14982, 16'd20093, 16'd21155, 16'd14588,
    16'd14418, 16'd17269, 16'd19674, 16'd13166,
    16'd11488, 16'd17354, 16'd17721, 16'd10702
  };

  function automatic logic [15:0] weight_lut(input logic [6:0] idx);
    logic [15:0] w;
    w = 16'd0;
    if (idx < 7'(WEIGHT_DEPTH)) begin
      w = WEIGHTS[idx[5:0]];
    end
    return w;
  endfunction

  typedef struct packed {
    logic capture;
    logic add;
    logic clear;
  } acc_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

endpackage

/* src/weighted_histogram_intersection_distance.sv */
`timescale 1ns / 1ps
// Weighted histogram intersection distance.
// in_*  : one bin pair per transaction, in_tlast on the final bin of a vector.
// out_* : one transaction per vector, distance in Q1.16 and a zero-norm flag.
// cfg_* : write-only registers, index 0 use_weights, index 1 block_length;
//         write only while no vector is in flight.
// Each bin has a capture state (min, then weight lookup and 16x16 multiply,
// or a shift by 16 without weights) and an accumulate state; in_tready is low
// during the accumulate state. A last bin then passes through a load state,
// the restoring divider (17 quotient bits, one per cycle, 46-bit
// compare/subtract, plus the registered done) and an output state that moves
// the result into the output register. A zero target sum skips the divider
// and goes from the load state straight to the output state.
// The output register lets the next vector stream in while a result waits;
// a stalled receiver blocks the next result and, with it, further input.
// Reset clears the accumulators, block counters, the output valid flag and
// sets use_weights to 0 and block_length to 64.
module weighted_histogram_intersection_distance #(
  parameter int BLOCK_COUNT = whid_pkg::BLOCK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] target_bin, [31:16] query_bin
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] distance, [23:17] zero
  output logic        out_tuser,  // [0] zero_norm
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_wdata
);
  import whid_pkg::*;

  state_t state_r, state_nxt;
  acc_ctl_t acc_ctl;

  logic             use_weights_r;
  logic [LEN_W-1:0] block_len_r;
  logic             last_r;
  logic             zero_r, zero_nxt;
  logic             div_start;
  logic             div_done;
  logic [QUOT_W-1:0] quot;
  logic [MIN_W-1:0]  min_sum;
  logic [TGT_W-1:0]  tgt_sum;
  logic [NUM_W-1:0]  num;
  logic              out_load;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] dist_r;
  logic              zn_r;
  logic [DIST_W-1:0] dist_val;
  logic              in_acc;

  assign in_acc = in_tvalid && in_tready;
  assign num    = {1'b0, min_sum, 1'b0} + NUM_W'(tgt_sum);

  whid_acc #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (acc_ctl),
    .use_weights(use_weights_r),
    .block_len  (block_len_r),
    .target_bin (in_tdata[15:0]),
    .query_bin  (in_tdata[31:16]),
    .min_sum    (min_sum),
    .tgt_sum    (tgt_sum)
  );

  whid_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (num),
    .den  (tgt_sum),
    .done (div_done),
    .quot (quot)
  );

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    acc_ctl     = '0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    zero_nxt    = zero_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready       = 1'b1;
        acc_ctl.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        acc_ctl.add = 1'b1;
        state_nxt   = last_r ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        zero_nxt = (tgt_sum == '0);
        if (tgt_sum == '0) begin
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          acc_ctl.clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (zero_r) begin
      dist_val = ONE_Q16;
    end else if (quot[QUOT_W-1]) begin
      dist_val = '0;
    end else begin
      dist_val = ONE_Q16 - {1'b0, quot[QUOT_W-2:0]};
    end
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      zero_r        <= 1'b0;
      use_weights_r <= 1'b0;
      block_len_r   <= LEN_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      zero_r      <= zero_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_USE_WEIGHTS: use_weights_r <= cfg_wdata[0];
          CFG_BLOCK_LEN:   block_len_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_r <= in_tlast;
    end
    if (out_load) begin
      dist_r <= dist_val;
      zn_r   <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, dist_r};
  assign out_tuser  = zn_r;

endmodule

/* src/whid_acc.sv */
`timescale 1ns / 1ps

module whid_acc #(
  parameter int BLOCK_COUNT = whid_pkg::BLOCK_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  whid_pkg::acc_ctl_t            ctl,
  input  logic                          use_weights,
  input  logic [whid_pkg::LEN_W-1:0]    block_len,
  input  logic [whid_pkg::BIN_W-1:0]    target_bin,
  input  logic [whid_pkg::BIN_W-1:0]    query_bin,
  output logic [whid_pkg::MIN_W-1:0]    min_sum,
  output logic [whid_pkg::TGT_W-1:0]    tgt_sum
);
  import whid_pkg::*;

  localparam int BLK_W = $clog2(BLOCK_COUNT + 1);

  logic [MIN_W-1:0]  min_r, min_nxt;
  logic [TGT_W-1:0]  tgt_r, tgt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [BIN_W-1:0]  t_r;
  logic [BIB_W-1:0]  bib_r, bib_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;

  logic [BIN_W-1:0] m;
  logic [LEN_W-1:0] len;
  logic [15:0]      w;
  logic [MIN_W:0]   msum;
  logic [TGT_W:0]   tsum;

  always_comb begin
    m = (query_bin < target_bin) ? query_bin : target_bin;
    priority if (block_len == '0) begin
      len = LEN_W'(1);
    end else if (block_len > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = block_len;
    end
    w = weight_lut(7'(blk_r));

    prod_nxt = prod_r;
    bib_nxt  = bib_r;
    blk_nxt  = blk_r;
    if (ctl.capture) begin
      if (use_weights) begin
        if (blk_r < BLK_W'(BLOCK_COUNT)) begin
          prod_nxt = m * w;
          if ((LEN_W'(bib_r) + LEN_W'(1)) >= len) begin
            bib_nxt = '0;
            blk_nxt = blk_r + BLK_W'(1);
          end else begin
            bib_nxt = bib_r + BIB_W'(1);
          end
        end else begin
          prod_nxt = '0;
        end
      end else begin
        prod_nxt = {m, 16'd0};
      end
    end
    if (ctl.clear) begin
      bib_nxt = '0;
      blk_nxt = '0;
    end

    msum = {1'b0, min_r} + (MIN_W + 1)'(prod_r);
    tsum = {1'b0, tgt_r} + (TGT_W + 1)'(t_r);
    min_nxt = min_r;
    tgt_nxt = tgt_r;
    if (ctl.add) begin
      min_nxt = msum[MIN_W] ? '1 : msum[MIN_W-1:0];
      tgt_nxt = tsum[TGT_W] ? '1 : tsum[TGT_W-1:0];
    end
    if (ctl.clear) begin
      min_nxt = '0;
      tgt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      tgt_r <= '0;
      bib_r <= '0;
      blk_r <= '0;
    end else begin
      min_r <= min_nxt;
      tgt_r <= tgt_nxt;
      bib_r <= bib_nxt;
      blk_r <= blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl.capture) begin
      t_r <= target_bin;
    end
  end

  assign min_sum = min_r;
  assign tgt_sum = tgt_r;

endmodule

/* src/whid_div.sv */
`timescale 1ns / 1ps

module whid_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [whid_pkg::NUM_W-1:0]   num,
  input  logic [whid_pkg::TGT_W-1:0]   den,
  output logic                         done,
  output logic [whid_pkg::QUOT_W-1:0]  quot
);
  import whid_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [DSH_W-1:0]  dsh_r, dsh_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  // restoring divide, one quotient bit per cycle, msb first
  always_comb begin
    ge       = rem_r >= NUM_W'(dsh_r);
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {den, 17'd0};
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(QUOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - NUM_W'(dsh_r);
      end
      q_nxt   = {q_r[QUOT_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
